/* rtl/yuvd_pkg.sv */
// Shared types, constants and a helper function for the decimating YUV to RGB565 unit.
`timescale 1ns / 1ps

package yuvd_pkg;

   // Size limits of the source and destination images.
   localparam int MAX_SRC_WIDTH  = 2048;
   localparam int MAX_SRC_HEIGHT = 2048;
   localparam int MAX_DST_WIDTH  = 256;
   localparam int MAX_DST_HEIGHT = 256;
   localparam int MAX_STEP       = 16;

   // Register field widths.
   localparam int SIZE_W  = 12;
   localparam int STEP_W  = 5;
   localparam int DST_W   = 9;
   localparam int INDEX_W = 3;

   // Counter widths.
   localparam int SRC_COL_W = $clog2(MAX_SRC_WIDTH);
   localparam int SRC_ROW_W = $clog2(MAX_SRC_HEIGHT);
   localparam int PHASE_W   = $clog2(MAX_STEP);

   // Register indexes of the configuration port.
   localparam logic [INDEX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [INDEX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [INDEX_W-1:0] CSR_STEP_X     = 3'd2;
   localparam logic [INDEX_W-1:0] CSR_STEP_Y     = 3'd3;
   localparam logic [INDEX_W-1:0] CSR_DST_WIDTH  = 3'd4;
   localparam logic [INDEX_W-1:0] CSR_DST_HEIGHT = 3'd5;

   // Register values after reset.
   localparam logic [SIZE_W-1:0] RST_SRC_WIDTH  = 12'd1280;
   localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT = 12'd720;
   localparam logic [STEP_W-1:0] RST_STEP_X     = 5'd6;
   localparam logic [STEP_W-1:0] RST_STEP_Y     = 5'd8;
   localparam logic [DST_W-1:0]  RST_DST_WIDTH  = 9'd184;
   localparam logic [DST_W-1:0]  RST_DST_HEIGHT = 9'd96;

   // Q12 color conversion coefficients.
   localparam logic signed [13:0] COEF_R_V = 14'sd5614;
   localparam logic signed [13:0] COEF_G_V = 14'sd2859;
   localparam logic signed [13:0] COEF_G_U = 14'sd1383;
   localparam logic signed [13:0] COEF_B_U = 14'sd7096;
   localparam logic signed [9:0]  CHROMA_OFFSET = 10'sd128;

   // One source pixel as it arrives on the request channel.
   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
      logic       frame_start;
   } req_payload_type;

   // One converted destination pixel.
   typedef struct packed {
      logic [15:0] pixel_rgb565;
      logic [7:0]  dst_col;
      logic [7:0]  dst_row;
      logic [15:0] dst_index;
   } rsp_payload_type;

   // Configuration after saturation into the legal ranges.
   typedef struct packed {
      logic [SIZE_W-1:0] src_width;
      logic [SIZE_W-1:0] src_height;
      logic [STEP_W-1:0] step_x;
      logic [STEP_W-1:0] step_y;
      logic [DST_W-1:0]  dst_width;
      logic [DST_W-1:0]  dst_height;
   } cfg_type;

   // Keep decision and destination position of the pixel being accepted.
   typedef struct packed {
      logic       keep;
      logic [7:0] col;
      logic [7:0] row;
   } pos_type;

   // Zero reads as one, anything above the cap reads as the cap.
   function automatic logic [SIZE_W-1:0] sat_cfg(input logic [SIZE_W-1:0] value,
                                                 input logic [SIZE_W-1:0] cap);
      logic [SIZE_W-1:0] result;
      if (value == '0) begin
         result = SIZE_W'(1);
      end else if (value > cap) begin
         result = cap;
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

/* rtl/yuvd_position.sv */
// Source position counters and decimation keep decision.
`timescale 1ns / 1ps

module yuvd_position
   import yuvd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  logic    frame_start,
   input  cfg_type cfg,
   output pos_type pos
);

   logic [SRC_COL_W-1:0] src_col_ff, src_col_in, src_col_cur;
   logic [SRC_ROW_W-1:0] src_row_ff, src_row_in, src_row_cur;
   logic [PHASE_W-1:0]   col_phase_ff, col_phase_in, col_phase_cur;
   logic [PHASE_W-1:0]   row_phase_ff, row_phase_in, row_phase_cur;
   logic [DST_W-1:0]     out_col_ff, out_col_in, out_col_cur;
   logic [DST_W-1:0]     out_row_ff, out_row_in, out_row_cur;
   logic                 keep_col, keep_row, col_open, row_open;
   logic                 row_end, frame_end;
   logic [STEP_W-1:0]    col_phase_inc, row_phase_inc;

   // A frame start clears the counters before the pixel is looked at.
   always_comb begin
      src_col_cur   = frame_start ? '0 : src_col_ff;
      src_row_cur   = frame_start ? '0 : src_row_ff;
      col_phase_cur = frame_start ? '0 : col_phase_ff;
      row_phase_cur = frame_start ? '0 : row_phase_ff;
      out_col_cur   = frame_start ? '0 : out_col_ff;
      out_row_cur   = frame_start ? '0 : out_row_ff;
   end

   // Keep decision for the current pixel.
   assign keep_col = (col_phase_cur == '0);
   assign keep_row = (row_phase_cur == '0);
   assign col_open = (out_col_cur < cfg.dst_width);
   assign row_open = (out_row_cur < cfg.dst_height);

   assign pos.keep = keep_col && keep_row && col_open && row_open;
   assign pos.col  = out_col_cur[7:0];
   assign pos.row  = out_row_cur[7:0];

   // End of row and end of frame tests.
   assign row_end   = ((SIZE_W'(src_col_cur) + SIZE_W'(1)) >= cfg.src_width);
   assign frame_end = ((SIZE_W'(src_row_cur) + SIZE_W'(1)) >= cfg.src_height);
   assign col_phase_inc = STEP_W'(col_phase_cur) + STEP_W'(1);
   assign row_phase_inc = STEP_W'(row_phase_cur) + STEP_W'(1);

   // Counter advance after the pixel.
   always_comb begin
      src_col_in   = src_col_cur;
      src_row_in   = src_row_cur;
      col_phase_in = col_phase_cur;
      row_phase_in = row_phase_cur;
      out_col_in   = out_col_cur;
      out_row_in   = out_row_cur;
      if (row_end) begin
         src_col_in   = '0;
         col_phase_in = '0;
         out_col_in   = '0;
         if (frame_end) begin
            src_row_in   = '0;
            row_phase_in = '0;
            out_row_in   = '0;
         end else begin
            src_row_in   = src_row_cur + SRC_ROW_W'(1);
            if (keep_row && row_open) begin
               out_row_in = out_row_cur + DST_W'(1);
            end
            row_phase_in = (row_phase_inc >= cfg.step_y) ? '0 : row_phase_inc[PHASE_W-1:0];
         end
      end else begin
         src_col_in = src_col_cur + SRC_COL_W'(1);
         if (keep_col && col_open) begin
            out_col_in = out_col_cur + DST_W'(1);
         end
         col_phase_in = (col_phase_inc >= cfg.step_x) ? '0 : col_phase_inc[PHASE_W-1:0];
      end
   end

   // Counters move only when a request is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         col_phase_ff <= '0;
         row_phase_ff <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
      end else if (accept) begin
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         col_phase_ff <= col_phase_in;
         row_phase_ff <= row_phase_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
      end
   end

endmodule

/* rtl/yuvd_convert.sv */
// Q12 YCbCr to RGB565 color conversion with clamping.
`timescale 1ns / 1ps

module yuvd_convert
   import yuvd_pkg::*;
(
   input  logic [7:0]  luma,
   input  logic [7:0]  chroma_u,
   input  logic [7:0]  chroma_v,
   output logic [15:0] pixel_rgb565
);

   logic signed [9:0]  diff_u, diff_v;
   logic signed [24:0] luma_term;
   logic signed [24:0] prod_r_v, prod_g_v, prod_g_u, prod_b_u;
   logic signed [24:0] sum_r, sum_g, sum_b;
   logic [7:0]         red, green, blue;

   // Floor by an arithmetic shift, then clamp to 0..255.
   function automatic logic [7:0] clamp_q12(input logic signed [24:0] sum);
      logic signed [12:0] whole;
      logic [7:0]         result;
      whole = sum[24:12];
      if (whole[12]) begin
         result = 8'd0;
      end else if (whole[11:8] != 4'd0) begin
         result = 8'd255;
      end else begin
         result = whole[7:0];
      end
      return result;
   endfunction

   // Chroma offsets removed.
   assign diff_u = $signed({2'b00, chroma_u}) - CHROMA_OFFSET;
   assign diff_v = $signed({2'b00, chroma_v}) - CHROMA_OFFSET;
   assign luma_term = {5'd0, luma, 12'd0};

   // Constant multiplies.
   assign prod_r_v = COEF_R_V * diff_v;
   assign prod_g_v = COEF_G_V * diff_v;
   assign prod_g_u = COEF_G_U * diff_u;
   assign prod_b_u = COEF_B_U * diff_u;

   // Channel sums in Q12.
   assign sum_r = luma_term + prod_r_v;
   assign sum_g = luma_term - prod_g_v - prod_g_u;
   assign sum_b = luma_term + prod_b_u;

   assign red   = clamp_q12(sum_r);
   assign green = clamp_q12(sum_g);
   assign blue  = clamp_q12(sum_b);

   // Pack into 5-6-5.
   assign pixel_rgb565 = {red[7:3], green[7:2], blue[7:3]};

endmodule

/* rtl/yuv_decimate_to_rgb565_unit.sv */
// Top level of the decimating YUV to RGB565 unit: registers, pipeline and handshakes.
`timescale 1ns / 1ps
// A kept request is registered in the first stage, then in the response register.
// Throughput: one request per cycle unless rsp_stall holds; dropped pixels produce no response.
// The position counters advance at acceptance; conversion and index run in the second stage.
// Reset clears the position counters and pipeline valids and loads the default registers.

module yuv_decimate_to_rgb565_unit
   import yuvd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_payload_type     req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_payload_type     rsp_payload,
   input  logic                csr_wr_en,
   input  logic [INDEX_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0]   csr_wdata
);

   logic [SIZE_W-1:0] src_width_ff, src_height_ff;
   logic [STEP_W-1:0] step_x_ff, step_y_ff;
   logic [DST_W-1:0]  dst_width_ff, dst_height_ff;
   cfg_type           cfg;

   logic              accept, blocked, stage_load;
   pos_type           pos;

   logic              stage_valid_ff;
   logic [7:0]        stage_luma_ff, stage_u_ff, stage_v_ff;
   logic [7:0]        stage_col_ff, stage_row_ff;

   logic [15:0]       pixel;
   logic [15:0]       index_full;
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= RST_SRC_WIDTH;
         src_height_ff <= RST_SRC_HEIGHT;
         step_x_ff     <= RST_STEP_X;
         step_y_ff     <= RST_STEP_Y;
         dst_width_ff  <= RST_DST_WIDTH;
         dst_height_ff <= RST_DST_HEIGHT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            CSR_STEP_X:     step_x_ff     <= csr_wdata[STEP_W-1:0];
            CSR_STEP_Y:     step_y_ff     <= csr_wdata[STEP_W-1:0];
            CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata[DST_W-1:0];
            CSR_DST_HEIGHT: dst_height_ff <= csr_wdata[DST_W-1:0];
            default: ;
         endcase
      end
   end

   // Registers saturated into their legal ranges.
   always_comb begin
      cfg.src_width  = sat_cfg(src_width_ff, SIZE_W'(MAX_SRC_WIDTH));
      cfg.src_height = sat_cfg(src_height_ff, SIZE_W'(MAX_SRC_HEIGHT));
      cfg.step_x     = STEP_W'(sat_cfg(SIZE_W'(step_x_ff), SIZE_W'(MAX_STEP)));
      cfg.step_y     = STEP_W'(sat_cfg(SIZE_W'(step_y_ff), SIZE_W'(MAX_STEP)));
      cfg.dst_width  = DST_W'(sat_cfg(SIZE_W'(dst_width_ff), SIZE_W'(MAX_DST_WIDTH)));
      cfg.dst_height = DST_W'(sat_cfg(SIZE_W'(dst_height_ff), SIZE_W'(MAX_DST_HEIGHT)));
   end

   // Handshake: the first stage loads whenever it is empty or drains forward.
   assign blocked    = rsp_valid_ff && rsp_stall;
   assign stage_load = !stage_valid_ff || !blocked;
   assign req_stall  = !stage_load;
   assign accept     = req_valid && !req_stall;

   yuvd_position u_position (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_payload.frame_start),
      .cfg         (cfg),
      .pos         (pos)
   );

   // First stage: the kept pixel and its destination position.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (stage_load) begin
         stage_valid_ff <= accept && pos.keep;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load) begin
         stage_luma_ff <= req_payload.luma;
         stage_u_ff    <= req_payload.chroma_u;
         stage_v_ff    <= req_payload.chroma_v;
         stage_col_ff  <= pos.col;
         stage_row_ff  <= pos.row;
      end
   end

   yuvd_convert u_convert (
      .luma         (stage_luma_ff),
      .chroma_u     (stage_u_ff),
      .chroma_v     (stage_v_ff),
      .pixel_rgb565 (pixel)
   );

   // Linear destination index; a kept row is below 256 and the width at most 256,
   // so the sum always fits in 16 bits.
   assign index_full = 16'(stage_row_ff) * 16'(cfg.dst_width) + 16'(stage_col_ff);

   always_comb begin
      rsp_payload_in.pixel_rgb565 = pixel;
      rsp_payload_in.dst_col      = stage_col_ff;
      rsp_payload_in.dst_row      = stage_row_ff;
      rsp_payload_in.dst_index    = index_full;
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!blocked) begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!blocked) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
